/* src/stok_pkg.sv */
// Package for the source tokenizer: token kinds, scan modes, keyword table and helpers.
`timescale 1ns / 1ps

package stok_pkg;

  localparam int CNT_BITS_DEF   = 16;
  localparam int KW_MAX_LEN_DEF = 9;
  localparam int FIELD_W        = 16;
  localparam int KIND_W         = 6;
  localparam int KW_COUNT       = 16;
  localparam int KW_TEXT_MAX    = 9;

  localparam logic [KIND_W-1:0] K_EOF     = 6'd0;
  localparam logic [KIND_W-1:0] K_NUM     = 6'd1;
  localparam logic [KIND_W-1:0] K_IDENT   = 6'd2;
  localparam logic [KIND_W-1:0] K_STR     = 6'd3;
  localparam logic [KIND_W-1:0] K_KW0     = 6'd4;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd20;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd21;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd22;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd23;
  localparam logic [KIND_W-1:0] K_LT      = 6'd24;
  localparam logic [KIND_W-1:0] K_LE      = 6'd25;
  localparam logic [KIND_W-1:0] K_GT      = 6'd26;
  localparam logic [KIND_W-1:0] K_GE      = 6'd27;
  localparam logic [KIND_W-1:0] K_NOT     = 6'd28;
  localparam logic [KIND_W-1:0] K_NE      = 6'd29;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd30;
  localparam logic [KIND_W-1:0] K_EQ      = 6'd31;
  localparam logic [KIND_W-1:0] K_AND     = 6'd32;
  localparam logic [KIND_W-1:0] K_OR      = 6'd33;
  localparam logic [KIND_W-1:0] K_COMMA   = 6'd34;
  localparam logic [KIND_W-1:0] K_SEMI    = 6'd35;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd36;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd37;
  localparam logic [KIND_W-1:0] K_LBRACK  = 6'd38;
  localparam logic [KIND_W-1:0] K_RBRACK  = 6'd39;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd40;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd41;
  localparam logic [KIND_W-1:0] K_UNKNOWN = 6'd42;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // Keyword text is right-justified: the last character sits in the low byte.
  localparam logic [KW_TEXT_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
    "num", "str", "bool", "array", "object", "auto", "true", "false",
    "show", "when", "otherwise", "repeat", "while", "function", "return", "ask"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd4, 4'd5,
    4'd4, 4'd4, 4'd9, 4'd6, 4'd5, 4'd8, 4'd6, 4'd3
  };

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_NUM     = 6'b000010,
    M_IDENT   = 6'b000100,
    M_STR     = 6'b001000,
    M_OP      = 6'b010000,
    M_COMMENT = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] len;
    logic [7:0]         bad;
    logic               last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_pend_op(input logic [7:0] c);
    return c inside {CH_MINUS, CH_SLASH, CH_LT, CH_GT, CH_BANG, CH_EQ, CH_AMP, CH_BAR};
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "+":     k = K_PLUS;
      "*":     k = K_STAR;
      ",":     k = K_COMMA;
      ";":     k = K_SEMI;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] p, input logic pair);
    logic [KIND_W-1:0] k;
    case (p)
      CH_MINUS: k = K_MINUS;
      CH_SLASH: k = K_SLASH;
      CH_LT:    k = pair ? K_LE : K_LT;
      CH_GT:    k = pair ? K_GE : K_GT;
      CH_BANG:  k = pair ? K_NE : K_NOT;
      CH_EQ:    k = pair ? K_EQ : K_ASSIGN;
      CH_AMP:   k = K_AND;
      default:  k = K_OR;
    endcase
    return k;
  endfunction

endpackage

/* src/source_tokenizer.sv */
// Source tokenizer top level: streaming lexer with a small result queue.
//
// The in_ channel carries one source byte per beat in in_tdata; a zero byte
// ends the source. The out_ channel carries one token per beat: its kind in
// out_tuser, its start line, start column, length and offending byte in
// out_tdata, and out_tlast on the final token caused by one input beat.
// Each input byte is scanned in the cycle it is accepted and its tokens (none,
// one or two) are written into a four-entry result queue that feeds out_.
// One byte is accepted every cycle while the queue holds at most two tokens;
// a byte that ends a token and also makes one of its own adds a second queue
// entry, so a run of such bytes drains at one token per cycle. When the
// receiver stalls, the queue fills and in_tready drops until it has room for
// two more tokens. Reset clears the queue and returns the scanner to line 1,
// column 1 between tokens; a zero byte, after its end-of-source token, returns
// the scanner there too but leaves the queue as it is.
`timescale 1ns / 1ps

module source_tokenizer #(
  parameter int COUNT_BITS      = stok_pkg::CNT_BITS_DEF,
  parameter int KEYWORD_MAX_LEN = stok_pkg::KW_MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] start_line, [31:16] start_column,
                                  // [47:32] length, [55:48] bad_char
  output logic [5:0]  out_tuser,  // [5:0] kind
  output logic        out_tlast
);

  import stok_pkg::*;

  localparam int KW_IDX_BITS = $clog2(KEYWORD_MAX_LEN);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt;
  cnt_t        line_r, line_nxt;
  cnt_t        col_r, col_nxt;
  cnt_t        tline_r, tline_nxt;
  cnt_t        tcol_r, tcol_nxt;
  cnt_t        tlen_r, tlen_nxt;
  logic [7:0]  kwbuf_r [KEYWORD_MAX_LEN];
  logic        kw_we;
  logic [KW_IDX_BITS-1:0] kw_idx;

  tok_t        fifo_r [4];
  logic [1:0]  head_r, tail_r;
  logic [2:0]  count_r;

  logic [7:0]  ch;
  logic        acc, pop;
  logic        v1, v2, push_a, push_b;
  tok_t        res1, res2, slot_a, slot_b;
  logic [KW_COUNT-1:0] kw_hit;
  logic [KIND_W-1:0]   ident_kind;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] k, input cnt_t ln, input cnt_t cl,
                                  input cnt_t n, input logic [7:0] b);
    tok_t t;
    t.kind = k;
    t.line = FIELD_W'(ln);
    t.col  = FIELD_W'(cl);
    t.len  = FIELD_W'(n);
    t.bad  = b;
    t.last = 1'b0;
    return t;
  endfunction

  assign ch         = in_tdata[7:0];
  assign in_tready  = (count_r <= 3'd2);
  assign acc        = in_tvalid & in_tready;
  assign out_tvalid = (count_r != 3'd0);
  assign pop        = out_tvalid & out_tready;

  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      kw_hit[i] = (tlen_r == COUNT_BITS'(KW_LEN[i]));
      for (int j = 0; j < KW_TEXT_MAX; j++) begin
        if (j < int'(KW_LEN[i])) begin
          if (kwbuf_r[KW_IDX_BITS'(j)] != KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j) * 8 +: 8]) begin
            kw_hit[i] = 1'b0;
          end
        end
      end
    end
    ident_kind = K_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (kw_hit[i]) begin
        ident_kind = KIND_W'(int'(K_KW0) + i);
      end
    end
  end

  always_comb begin
    logic used;
    logic eof;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    tlen_nxt  = tlen_r;
    kw_we     = 1'b0;
    kw_idx    = tlen_r[KW_IDX_BITS-1:0];
    v1        = 1'b0;
    v2        = 1'b0;
    res1      = mk_tok(K_EOF, tline_r, tcol_r, tlen_r, 8'h00);
    res2      = res1;
    used      = 1'b0;
    eof       = 1'b0;

    // Finish or extend the token in progress.
    case (mode_r)
      M_NUM: begin
        if (is_digit(ch)) begin
          tlen_nxt = sat_inc(tlen_r);
          used     = 1'b1;
        end else begin
          v1       = 1'b1;
          res1     = mk_tok(K_NUM, tline_r, tcol_r, tlen_r, 8'h00);
          mode_nxt = M_IDLE;
        end
      end
      M_IDENT: begin
        if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
          kw_we    = (tlen_r < COUNT_BITS'(KEYWORD_MAX_LEN));
          tlen_nxt = sat_inc(tlen_r);
          used     = 1'b1;
        end else begin
          v1       = 1'b1;
          res1     = mk_tok(ident_kind, tline_r, tcol_r, tlen_r, 8'h00);
          mode_nxt = M_IDLE;
        end
      end
      M_STR: begin
        if (ch == CH_QUOTE || ch == CH_NUL) begin
          v1       = 1'b1;
          res1     = mk_tok(K_STR, tline_r, tcol_r, tlen_r, 8'h00);
          mode_nxt = M_IDLE;
          used     = (ch != CH_NUL);
        end else begin
          tlen_nxt = sat_inc(tlen_r);
          used     = 1'b1;
        end
      end
      M_COMMENT: begin
        if (ch == CH_NUL) begin
          mode_nxt = M_IDLE;
        end else begin
          used = 1'b1;
          if (ch == CH_LF) begin
            mode_nxt = M_IDLE;
          end
        end
      end
      M_OP: begin
        mode_nxt = M_IDLE;
        pend_nxt = 8'h00;
        if (pend_r == CH_MINUS && is_digit(ch)) begin
          mode_nxt = M_NUM;
          tlen_nxt = COUNT_BITS'(2);
          used     = 1'b1;
        end else if (pend_r == CH_SLASH && ch == CH_SLASH) begin
          mode_nxt = M_COMMENT;
          used     = 1'b1;
        end else if (pend_r inside {CH_LT, CH_GT, CH_BANG, CH_EQ} && ch == CH_EQ) begin
          v1   = 1'b1;
          res1 = mk_tok(op_kind(pend_r, 1'b1), tline_r, tcol_r, COUNT_BITS'(2), 8'h00);
          used = 1'b1;
        end else if (pend_r inside {CH_AMP, CH_BAR} && ch == pend_r) begin
          v1   = 1'b1;
          res1 = mk_tok(op_kind(pend_r, 1'b1), tline_r, tcol_r, COUNT_BITS'(2), 8'h00);
          used = 1'b1;
        end else if (pend_r inside {CH_AMP, CH_BAR}) begin
          v1   = 1'b1;
          res1 = mk_tok(K_UNKNOWN, tline_r, tcol_r, COUNT_BITS'(1), pend_r);
        end else begin
          v1   = 1'b1;
          res1 = mk_tok(op_kind(pend_r, 1'b0), tline_r, tcol_r, COUNT_BITS'(1), 8'h00);
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    // Handle a byte that the current token did not take: skip space, end the source, or start a new token.
    if (!used) begin
      if (ch == CH_NUL) begin
        eof  = 1'b1;
        v2   = 1'b1;
        res2 = mk_tok(K_EOF, line_r, col_r, '0, 8'h00);
      end else if (is_space(ch)) begin
        mode_nxt = mode_nxt;
      end else if (is_digit(ch)) begin
        tline_nxt = line_r;
        tcol_nxt  = col_r;
        tlen_nxt  = COUNT_BITS'(1);
        mode_nxt  = M_NUM;
      end else if (is_alpha(ch) || ch == CH_UNDER) begin
        tline_nxt = line_r;
        tcol_nxt  = col_r;
        tlen_nxt  = COUNT_BITS'(1);
        kw_we     = 1'b1;
        kw_idx    = '0;
        mode_nxt  = M_IDENT;
      end else if (ch == CH_QUOTE) begin
        tline_nxt = line_r;
        tcol_nxt  = col_r;
        tlen_nxt  = '0;
        mode_nxt  = M_STR;
      end else if (single_kind(ch) != K_EOF) begin
        v2   = 1'b1;
        res2 = mk_tok(single_kind(ch), line_r, col_r, COUNT_BITS'(1), 8'h00);
      end else if (is_pend_op(ch)) begin
        tline_nxt = line_r;
        tcol_nxt  = col_r;
        pend_nxt  = ch;
        mode_nxt  = M_OP;
      end else begin
        v2   = 1'b1;
        res2 = mk_tok(K_UNKNOWN, line_r, col_r, COUNT_BITS'(1), ch);
      end
    end

    if (eof) begin
      mode_nxt  = M_IDLE;
      pend_nxt  = 8'h00;
      line_nxt  = COUNT_BITS'(1);
      col_nxt   = COUNT_BITS'(1);
      tline_nxt = COUNT_BITS'(1);
      tcol_nxt  = COUNT_BITS'(1);
      tlen_nxt  = '0;
    end else if (ch == CH_LF) begin
      line_nxt = sat_inc(line_r);
      col_nxt  = COUNT_BITS'(1);
    end else begin
      col_nxt = sat_inc(col_r);
    end

    slot_a      = v1 ? res1 : res2;
    slot_b      = res2;
    slot_a.last = !(v1 && v2);
    slot_b.last = 1'b1;
    push_a      = acc && (v1 || v2);
    push_b      = acc && v1 && v2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pend_r  <= 8'h00;
      line_r  <= COUNT_BITS'(1);
      col_r   <= COUNT_BITS'(1);
      tline_r <= COUNT_BITS'(1);
      tcol_r  <= COUNT_BITS'(1);
      tlen_r  <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (acc) begin
        mode_r  <= mode_nxt;
        pend_r  <= pend_nxt;
        line_r  <= line_nxt;
        col_r   <= col_nxt;
        tline_r <= tline_nxt;
        tcol_r  <= tcol_nxt;
        tlen_r  <= tlen_nxt;
      end
      head_r  <= head_r + 2'(pop);
      tail_r  <= tail_r + 2'(push_a) + 2'(push_b);
      count_r <= count_r + 3'(push_a) + 3'(push_b) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && kw_we) begin
      kwbuf_r[kw_idx] <= ch;
    end
    if (push_a) begin
      fifo_r[tail_r] <= slot_a;
    end
    if (push_b) begin
      fifo_r[tail_r + 2'd1] <= slot_b;
    end
  end

  assign out_tuser = fifo_r[head_r].kind;
  assign out_tdata = {fifo_r[head_r].bad, fifo_r[head_r].len,
                      fifo_r[head_r].col, fifo_r[head_r].line};
  assign out_tlast = fifo_r[head_r].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("result queue holds more than four tokens");

  a_eof_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ch == CH_NUL) |-> (push_a && (push_b ? slot_b.kind == K_EOF
                                                 : slot_a.kind == K_EOF)))
    else $error("end of source did not queue an end-of-source token");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ch == CH_NUL) |=> (mode_r == M_IDLE && line_r == COUNT_BITS'(1)
                               && col_r == COUNT_BITS'(1)))
    else $error("position tracking did not restart after end of source");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != '0) && (col_r != '0))
    else $error("line or column counter reached zero");

endmodule
